FILE: rtl/core/stuffed_frame_deframer_unit_defines.svh
// Assertion macros used by the checker file.
`ifndef STUFFED_FRAME_DEFRAMER_UNIT_DEFINES_SVH
`define STUFFED_FRAME_DEFRAMER_UNIT_DEFINES_SVH

// Same-cycle implication, quiet during reset.
`define SFD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sfd check failed: same-cycle rule");

// Next-cycle implication, quiet during reset.
`define SFD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sfd check failed: next-cycle rule");

`endif

FILE: rtl/core/sfd_pkg.sv
`default_nettype none
package sfd_pkg;

  // Link bytes with special meaning
  localparam logic [7:0] SYNC_BYTE = 8'hE0;
  localparam logic [7:0] ESC_BYTE  = 8'hD0;
  localparam logic [7:0] ESC_ADD   = 8'd1;

  // Frame overhead beyond the payload length
  localparam logic [8:0] LEN_OVERHEAD = 9'd5;
  // Index of the length byte within a frame
  localparam logic [8:0] LEN_INDEX    = 9'd3;

  localparam logic [8:0] FRAME_LIMIT_RESET = 9'd260;

  // Result status codes
  typedef enum logic [2:0] {
    ST_CONT     = 3'd0,
    ST_OK       = 3'd1,
    ST_CSUM     = 3'd2,
    ST_FRAMING  = 3'd3,
    ST_OVERFLOW = 3'd4
  } status_t;

  // Classified link byte, passed from front to back
  typedef struct packed {
    logic [7:0] data;
    logic       is_sync;
    logic       is_esc;
  } item_t;

endpackage
`default_nettype wire

FILE: rtl/core/stuffed_frame_deframer_unit.sv
// Byte-stuffed frame deframer: takes one raw link byte per transaction on the
// s_ side and gives at most one unstuffed frame byte or frame status per byte
// on the m_ side. Sustained rate is one byte per clock while m_tready is held
// high; the limit is the per-byte state update in the back end (compare, add,
// count). A result passes through the two-entry input queue and then the
// output register: the byte is decoded straight from the queue head into it.
// Bytes dropped while hunting for sync give no transaction; escape bytes give
// none unless they end the frame with an error. frame_limit (cfg_wdata,
// reset 260) is written with cfg_we while idle: user's duty, not enforced.
`default_nettype none
module stuffed_frame_deframer_unit (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [8:0] cfg_wdata,  // [8:0] frame_limit
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,    // [7:0] in_byte
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,    // [7:0] out_byte
  output logic [3:0]      m_tuser,    // [0] byte_valid, [3:1] status
  output logic            m_tlast     // frame_end
);

  logic           q_valid;
  logic           q_pop;
  sfd_pkg::item_t q_item;

  // Front end: accept and classify
  sfd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  // Back end: frame state and results
  sfd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule
`default_nettype wire

FILE: rtl/core/sfd_front.sv
`default_nettype none
// Accepts link bytes, tags sync and escape, and holds them in a two-entry queue.
module sfd_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           s_tvalid,
  output logic                s_tready,
  input  wire logic [7:0]     s_tdata,   // [7:0] in_byte
  output logic                q_valid,
  output sfd_pkg::item_t      q_item,
  input  wire logic           q_pop
);

  sfd_pkg::item_t slots [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           push;
  sfd_pkg::item_t item_in;

  // Classify the incoming byte
  always_comb begin
    item_in.data    = s_tdata;
    item_in.is_sync = (s_tdata == sfd_pkg::SYNC_BYTE);
    item_in.is_esc  = (s_tdata == sfd_pkg::ESC_BYTE);
  end

  assign s_tready = (count != 2'd2);
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (count != 2'd0);
  assign q_item   = slots[rd_ptr];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= item_in;
    end
  end

  // Queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, q_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/sfd_back.sv
`default_nettype none
// Runs the frame state for each queued byte and holds the result in an output register.
module sfd_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cfg_we,
  input  wire logic [8:0]     cfg_wdata,
  input  wire logic           q_valid,
  input  wire sfd_pkg::item_t q_item,
  output logic                q_pop,
  output logic                m_tvalid,
  input  wire logic           m_tready,
  output logic [7:0]          m_tdata,   // [7:0] out_byte
  output logic [3:0]          m_tuser,   // [0] byte_valid, [3:1] status
  output logic                m_tlast    // frame_end
);

  typedef enum logic {HUNT, FRAME} state_t;

  state_t           state, state_next;
  logic             esc_pend, esc_pend_next;
  logic [8:0]       byte_count, byte_count_next;
  logic [7:0]       running_sum, running_sum_next;
  logic [7:0]       payload_length, payload_length_next;
  logic [8:0]       frame_limit;

  logic             res_valid;
  logic [7:0]       res_byte;
  logic             res_bvalid;
  logic             res_end;
  sfd_pkg::status_t res_status;

  logic [7:0]       ubyte;
  logic [8:0]       cnt_inc;
  logic [7:0]       len_eff;
  logic [8:0]       end_count;

  // Take the queue head whenever the output register is free or draining
  assign q_pop = q_valid && (!m_tvalid || m_tready);

  // Unstuffed byte, its count and the frame end point
  always_comb begin
    ubyte     = esc_pend ? (q_item.data + sfd_pkg::ESC_ADD) : q_item.data;
    cnt_inc   = byte_count + 9'd1;
    len_eff   = (byte_count == sfd_pkg::LEN_INDEX) ? ubyte : payload_length;
    end_count = {1'b0, len_eff} + sfd_pkg::LEN_OVERHEAD;
  end

  // Frame decoding for one byte
  always_comb begin
    state_next          = state;
    esc_pend_next       = esc_pend;
    byte_count_next     = byte_count;
    running_sum_next    = running_sum;
    payload_length_next = payload_length;
    res_valid           = 1'b0;
    res_byte            = 8'd0;
    res_bvalid          = 1'b0;
    res_end             = 1'b0;
    res_status          = sfd_pkg::ST_CONT;
    case (state)
      HUNT: begin
        if (q_item.is_sync) begin
          res_valid = 1'b1;
          if (frame_limit == 9'd0) begin
            res_end    = 1'b1;
            res_status = sfd_pkg::ST_OVERFLOW;
          end else begin
            state_next       = FRAME;
            esc_pend_next    = 1'b0;
            byte_count_next  = 9'd1;
            running_sum_next = 8'd0;
            res_byte         = q_item.data;
            res_bvalid       = 1'b1;
          end
        end
      end
      FRAME: begin
        if (byte_count >= frame_limit) begin
          res_valid  = 1'b1;
          res_end    = 1'b1;
          res_status = sfd_pkg::ST_OVERFLOW;
          state_next = HUNT;
        end else if (q_item.is_sync || (q_item.is_esc && esc_pend)) begin
          res_valid  = 1'b1;
          res_end    = 1'b1;
          res_status = sfd_pkg::ST_FRAMING;
          state_next = HUNT;
        end else if (q_item.is_esc) begin
          esc_pend_next = 1'b1;
        end else begin
          esc_pend_next   = 1'b0;
          byte_count_next = cnt_inc;
          if (byte_count == sfd_pkg::LEN_INDEX) begin
            payload_length_next = ubyte;
          end
          res_valid  = 1'b1;
          res_byte   = ubyte;
          res_bvalid = 1'b1;
          if (cnt_inc >= sfd_pkg::LEN_OVERHEAD && cnt_inc == end_count) begin
            res_end    = 1'b1;
            res_status = (running_sum == ubyte) ? sfd_pkg::ST_OK : sfd_pkg::ST_CSUM;
            state_next = HUNT;
          end else begin
            running_sum_next = running_sum + ubyte;
          end
        end
      end
      default: state_next = HUNT;
    endcase
    // Leaving a frame clears the per-frame state
    if (state_next == HUNT) begin
      esc_pend_next    = 1'b0;
      byte_count_next  = 9'd0;
      running_sum_next = 8'd0;
    end
  end

  // State, configuration and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= HUNT;
      esc_pend       <= 1'b0;
      byte_count     <= 9'd0;
      running_sum    <= 8'd0;
      payload_length <= 8'd0;
      frame_limit    <= sfd_pkg::FRAME_LIMIT_RESET;
      m_tvalid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        frame_limit <= cfg_wdata;
      end
      if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (q_pop) begin
        state          <= state_next;
        esc_pend       <= esc_pend_next;
        byte_count     <= byte_count_next;
        running_sum    <= running_sum_next;
        payload_length <= payload_length_next;
        if (res_valid) begin
          m_tvalid <= 1'b1;
          m_tdata  <= res_byte;
          m_tuser  <= {res_status, res_bvalid};
          m_tlast  <= res_end;
        end
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/sfd_checker.sv
`default_nettype none
`include "stuffed_frame_deframer_unit_defines.svh"
// Port-level checks on the result stream.
module sfd_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       m_tvalid,
  input wire logic       m_tready,
  input wire logic [7:0] m_tdata,
  input wire logic [3:0] m_tuser,
  input wire logic       m_tlast
);

  // A stalled result holds
  `SFD_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

  // A result without a frame byte carries zero data
  `SFD_ASSERT_IMPL(a_nobyte_zero, m_tvalid && !m_tuser[0], m_tdata == 8'd0)

  // A result without a frame byte always ends the frame
  `SFD_ASSERT_IMPL(a_nobyte_end, m_tvalid && !m_tuser[0], m_tlast)

  // Status is final exactly on the frame end
  `SFD_ASSERT_IMPL(a_status_end, m_tvalid, m_tlast == (m_tuser[3:1] != sfd_pkg::ST_CONT))

endmodule

bind stuffed_frame_deframer_unit sfd_checker u_sfd_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
`default_nettype wire
